// ===== hdl/encrf_pkg.sv =====
// encrf_pkg: field widths, wrap limits and scale constants shared by the
// encoder unwrap and rate filter modules. No dependencies.
package encrf_pkg;

   // field widths
   localparam int POS_W    = 13;
   localparam int RATE_W   = 14;
   localparam int TURN_W   = 16;
   localparam int CONT_W   = 30;
   localparam int ANGLE_W  = 33;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 112;

   // default length of the rate averaging ring
   localparam int RATE_DEPTH_DEF = 8;

   // wrap detection on the 15-bit signed position difference
   localparam logic signed [RATE_W:0] WRAP_HI         = 15'sd7500;
   localparam logic signed [RATE_W:0] WRAP_LO         = -15'sd7500;
   localparam logic signed [RATE_W:0] COUNTS_PER_TURN = 15'sd8192;

   // saturation limits of the turn counter
   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

   // angle scale: counts to Q24.8 degrees is *45/4, one turn is 360*256
   localparam int ANG_PROD_W = 20;
   localparam logic signed [ANG_PROD_W-1:0] ANGLE_MUL   = 20'sd45;
   localparam logic signed [ANGLE_W-1:0]    Q8_PER_TURN = 33'sd92160;

   // one unwrapped step leaving the state update stage
   typedef struct packed {
      logic [POS_W-1:0]         pos;
      logic signed [RATE_W-1:0] rate;
      logic signed [TURN_W-1:0] turns;
   } step_type;

endpackage

// ===== hdl/encrf_ram.sv =====
// encrf_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module encrf_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/encrf_unwrap.sv =====
// encrf_unwrap: wrap detection, saturating turn count and running ring sum.
// Uses encrf_pkg and one encrf_ram for the ring of recent steps.
module encrf_unwrap #(
   parameter int RATE_DEPTH = encrf_pkg::RATE_DEPTH_DEF,
   parameter int SUM_W      = encrf_pkg::POS_W + $clog2(RATE_DEPTH) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [encrf_pkg::POS_W-1:0]   in_pos,
   output logic                          out_valid,
   input  logic                          out_ready,
   output encrf_pkg::step_type           out_step,
   output logic signed [SUM_W-1:0]       out_sum
);

   localparam int IDX_W = $clog2(RATE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RATE_DEPTH - 1);

   logic [encrf_pkg::POS_W-1:0]          prev_ff, prev_in;
   logic signed [encrf_pkg::TURN_W-1:0]  turns_ff, turns_in;
   logic signed [encrf_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic signed [SUM_W-1:0]              sum_ff, sum_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic [RATE_DEPTH-1:0]                fill_ff, fill_in;
   logic                                 valid_ff, valid_in;
   logic                                 accept;
   logic signed [encrf_pkg::RATE_W:0]    diff;
   logic [encrf_pkg::RATE_W-1:0]         ring_rd;
   logic signed [encrf_pkg::RATE_W-1:0]  ring_old;

   // take a word whenever the step register is free or moving on
   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // ring entries not yet written since reset read as zero
   assign ring_old = fill_ff[idx_ff] ? $signed(ring_rd) : '0;

   // unwrap and state update
   always_comb begin
      diff     = $signed({2'b00, in_pos}) - $signed({2'b00, prev_ff});
      prev_in  = prev_ff;
      turns_in = turns_ff;
      rate_in  = rate_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         prev_in  = in_pos;
         if (diff < encrf_pkg::WRAP_LO) begin
            // forward wrap
            if (turns_ff != encrf_pkg::TURN_MAX) begin
               turns_in = turns_ff + 16'sd1;
            end
            rate_in = encrf_pkg::RATE_W'(diff + encrf_pkg::COUNTS_PER_TURN);
         end else if (diff > encrf_pkg::WRAP_HI) begin
            // backward wrap
            if (turns_ff != encrf_pkg::TURN_MIN) begin
               turns_in = turns_ff - 16'sd1;
            end
            rate_in = encrf_pkg::RATE_W'(diff - encrf_pkg::COUNTS_PER_TURN);
         end else begin
            rate_in = encrf_pkg::RATE_W'(diff);
         end
         sum_in = sum_ff + SUM_W'(rate_in) - SUM_W'(ring_old);
         fill_in[idx_ff] = 1'b1;
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         turns_ff <= '0;
         sum_ff   <= '0;
         idx_ff   <= '0;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         turns_ff <= turns_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   // step payload
   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
   end

   // ring of recent steps; read address is the slot that the next step overwrites
   encrf_ram #(
      .WIDTH (encrf_pkg::RATE_W),
      .DEPTH (RATE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx_ff),
      .wr_data (rate_in),
      .rd_addr (idx_in),
      .rd_data (ring_rd)
   );

   // the state registers double as the step register
   assign out_valid      = valid_ff;
   assign out_step.pos   = prev_ff;
   assign out_step.rate  = rate_ff;
   assign out_step.turns = turns_ff;
   assign out_sum        = sum_ff;

endmodule

// ===== hdl/encrf_scale.sv =====
// encrf_scale: mean rate by reciprocal multiply, continuous count and angle.
// Two register stages, the second is the result register. Uses encrf_pkg.
module encrf_scale #(
   parameter int RATE_DEPTH = encrf_pkg::RATE_DEPTH_DEF,
   parameter int SUM_W      = encrf_pkg::POS_W + $clog2(RATE_DEPTH) + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  encrf_pkg::step_type                 in_step,
   input  logic signed [SUM_W-1:0]             in_sum,
   input  logic [encrf_pkg::POS_W-1:0]         angle_bias,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [encrf_pkg::RATE_W-1:0] step_rate,
   output logic signed [encrf_pkg::RATE_W-1:0] filtered_rate,
   output logic signed [encrf_pkg::TURN_W-1:0] turn_count,
   output logic signed [encrf_pkg::CONT_W-1:0] continuous_count,
   output logic signed [encrf_pkg::ANGLE_W-1:0] angle_q8
);

   // divide by RATE_DEPTH: q = (|sum| * RECIP) >> SHIFT, exact for |sum| < 2^MAG_W
   localparam int MAG_W  = SUM_W - 1;
   localparam int LOG_D  = $clog2(RATE_DEPTH);
   localparam int SHIFT  = MAG_W + LOG_D;
   localparam int RCP_W  = MAG_W + 1;
   localparam int PROD_W = MAG_W + RCP_W;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(RATE_DEPTH) - 64'd1) / 64'(RATE_DEPTH);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
   localparam int ANGA_W = encrf_pkg::ANG_PROD_W - 2;

   logic                                   v2_ff, v3_ff;
   logic                                   en2, en3;
   logic                                   neg_ff;
   logic [PROD_W-1:0]                      prod_ff, prod_in;
   logic [MAG_W-1:0]                       mag;
   logic signed [encrf_pkg::RATE_W:0]      delta;
   logic signed [encrf_pkg::ANG_PROD_W-1:0] ang_prod;
   logic signed [ANGA_W-1:0]               anga_ff;
   logic signed [encrf_pkg::ANGLE_W-1:0]   angb_ff, angb_in;
   logic signed [encrf_pkg::RATE_W-1:0]    rate2_ff;
   logic signed [encrf_pkg::TURN_W-1:0]    turns2_ff;
   logic signed [encrf_pkg::CONT_W-1:0]    cont2_ff, cont_in;
   logic [encrf_pkg::RATE_W-1:0]           quot;
   logic signed [encrf_pkg::RATE_W-1:0]    rate3_ff, filt3_ff, filt_in;
   logic signed [encrf_pkg::TURN_W-1:0]    turns3_ff;
   logic signed [encrf_pkg::CONT_W-1:0]    cont3_ff;
   logic signed [encrf_pkg::ANGLE_W-1:0]   angle3_ff, angle_in;

   // each stage moves when the one after it is empty or moving
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;

   // stage 2 logic: magnitude product, count and angle partial terms
   always_comb begin
      mag      = MAG_W'(in_sum < 0 ? -in_sum : in_sum);
      prod_in  = PROD_W'(mag) * PROD_W'(RECIP);
      cont_in  = encrf_pkg::CONT_W'($signed({in_step.turns, in_step.pos}));
      delta    = $signed({2'b00, in_step.pos}) - $signed({2'b00, angle_bias});
      ang_prod = encrf_pkg::ANG_PROD_W'(delta) * encrf_pkg::ANGLE_MUL;
      angb_in  = encrf_pkg::ANGLE_W'(in_step.turns) * encrf_pkg::Q8_PER_TURN;
   end

   // stage 3 logic: signed quotient and angle sum
   always_comb begin
      quot     = prod_ff[PROD_W-1:SHIFT];
      filt_in  = neg_ff ? -$signed(quot) : $signed(quot);
      angle_in = angb_ff + encrf_pkg::ANGLE_W'(anga_ff);
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= in_valid;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 2 payload
   always_ff @(posedge clock) begin
      if (en2 && in_valid) begin
         neg_ff    <= in_sum < 0;
         prod_ff   <= prod_in;
         anga_ff   <= ANGA_W'(ang_prod >>> 2);
         angb_ff   <= angb_in;
         rate2_ff  <= in_step.rate;
         turns2_ff <= in_step.turns;
         cont2_ff  <= cont_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         rate3_ff  <= rate2_ff;
         filt3_ff  <= filt_in;
         turns3_ff <= turns2_ff;
         cont3_ff  <= cont2_ff;
         angle3_ff <= angle_in;
      end
   end

   assign out_valid        = v3_ff;
   assign step_rate        = rate3_ff;
   assign filtered_rate    = filt3_ff;
   assign turn_count       = turns3_ff;
   assign continuous_count = cont3_ff;
   assign angle_q8         = angle3_ff;

endmodule

// ===== hdl/encoder_unwrap_rate_filter_core.sv =====
// encoder_unwrap_rate_filter_core: top level of the encoder unwrap and rate
// filter. Uses encrf_pkg, encrf_unwrap, encrf_scale (and encrf_ram below).
//
//   port group  dir  payload
//   req_*       in   word: raw_position
//   rsp_*       out  word: step_rate, filtered_rate, turn_count,
//                          continuous_count, angle_q8
//   csr_*       in   angle_bias
//
// One word per cycle sustained while rsp_tready holds; each accepted word passes
// through the state update stage, multiply stage and result register.
// Reset is synchronous: position, turns, ring and bias clear at once, the
// ring through per-entry fill flags, so no clearing pass is needed.
// A stalled rsp side fills the empty stages first; req_tready drops only
// when every stage holds a word.
module encoder_unwrap_rate_filter_core #(
   parameter int RATE_DEPTH = encrf_pkg::RATE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // [12:0] raw_position, [15:13] zero
   input  logic [encrf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [13:0] step_rate, [27:14] filtered_rate, [43:28] turn_count,
   // [73:44] continuous_count, [106:74] angle_q8, [111:107] zero
   output logic [encrf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [encrf_pkg::POS_W-1:0]           csr_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready
);

   localparam int SUM_W = encrf_pkg::POS_W + $clog2(RATE_DEPTH) + 1;
   localparam int PAD_W = encrf_pkg::RSP_DATA_W - 2 * encrf_pkg::RATE_W
                          - encrf_pkg::TURN_W - encrf_pkg::CONT_W - encrf_pkg::ANGLE_W;

   logic [encrf_pkg::POS_W-1:0]           bias_ff;
   logic                                  step_valid, step_ready;
   encrf_pkg::step_type                   step;
   logic signed [SUM_W-1:0]               step_sum;
   logic signed [encrf_pkg::RATE_W-1:0]   step_rate, filtered_rate;
   logic signed [encrf_pkg::TURN_W-1:0]   turn_count;
   logic signed [encrf_pkg::CONT_W-1:0]   continuous_count;
   logic signed [encrf_pkg::ANGLE_W-1:0]  angle_q8;

   // bias register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (csr_valid) begin
         bias_ff <= csr_data;
      end
   end

   // unwrap and running ring sum
   encrf_unwrap #(
      .RATE_DEPTH (RATE_DEPTH),
      .SUM_W      (SUM_W)
   ) u_unwrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pos    (req_tdata[encrf_pkg::POS_W-1:0]),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_step  (step),
      .out_sum   (step_sum)
   );

   // mean rate, count and angle
   encrf_scale #(
      .RATE_DEPTH (RATE_DEPTH),
      .SUM_W      (SUM_W)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (step_valid),
      .in_ready         (step_ready),
      .in_step          (step),
      .in_sum           (step_sum),
      .angle_bias       (bias_ff),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .step_rate        (step_rate),
      .filtered_rate    (filtered_rate),
      .turn_count       (turn_count),
      .continuous_count (continuous_count),
      .angle_q8         (angle_q8)
   );

   // result word packing, first field lowest
   assign rsp_tdata = {PAD_W'(0), angle_q8, continuous_count, turn_count,
                       filtered_rate, step_rate};

endmodule
